/* src/horizontal_gradient_tint_macros.svh */
// assertion macros used by the gradient tint rtl
`ifndef HORIZONTAL_GRADIENT_TINT_MACROS_SVH
`define HORIZONTAL_GRADIENT_TINT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HGT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HGT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/hgt_pkg.sv */
// types and constants of the horizontal gradient tint pipeline
`timescale 1ns / 1ps

package hgt_pkg;

    localparam int COL_W     = 12;
    localparam int CH_W      = 8;
    localparam int WIDTH_W   = 13;
    localparam int CFG_W     = 13;
    localparam int REG_IDX_W = 3;
    localparam int NUM_CH    = 3;
    localparam int NUM_W     = 21;
    localparam int QUO_W     = 8;
    localparam int PROD_W    = 16;
    localparam int ROUND_BIAS = 127;

    typedef logic [CH_W-1:0] chan_t;
    typedef chan_t [NUM_CH-1:0] rgb_t;

    localparam chan_t CH_FULL = 8'd255;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMAGE_WIDTH = 3'd0,
        REG_LEFT_RED    = 3'd1,
        REG_LEFT_GREEN  = 3'd2,
        REG_LEFT_BLUE   = 3'd3,
        REG_RIGHT_RED   = 3'd4,
        REG_RIGHT_GREEN = 3'd5,
        REG_RIGHT_BLUE  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [COL_W-1:0] column;
        chan_t            in_red;
        chan_t            in_green;
        chan_t            in_blue;
        chan_t            in_alpha;
    } in_item_t;

    typedef struct packed {
        chan_t out_red;
        chan_t out_green;
        chan_t out_blue;
        chan_t out_alpha;
    } out_item_t;

    // clamped column and denominator
    typedef struct packed {
        logic [COL_W-1:0]   x;
        logic [WIDTH_W-1:0] d;
        rgb_t               rgb;
        chan_t              alpha;
    } lerp_t;

    // interpolation partial products
    typedef struct packed {
        logic [NUM_CH-1:0][NUM_W-1:0] lo;
        logic [NUM_CH-1:0][NUM_W-1:0] hi;
        logic [WIDTH_W-1:0]           d;
        rgb_t                         rgb;
        chan_t                        alpha;
    } prod_t;

    // restoring division step
    typedef struct packed {
        logic [NUM_CH-1:0][NUM_W-1:0] rem;
        logic [NUM_CH-1:0][QUO_W-1:0] quo;
        logic [WIDTH_W-1:0]           d;
        rgb_t                         rgb;
        chan_t                        alpha;
    } div_t;

    // pixel times tint plus rounding bias
    typedef struct packed {
        logic [NUM_CH-1:0][PROD_W-1:0] v;
        chan_t                         alpha;
    } scale_t;

endpackage

/* src/hgt_stream_if.sv */
// valid/ready stream channel carrying one packed payload
`timescale 1ns / 1ps

interface hgt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/horizontal_gradient_tint.sv */
// horizontal gradient multiply tint for rgba8 pixels, top level
// throughput: one pixel per cycle while the output accepts, set by the 14-stage pipeline with per-stage ready
// the eight quotient bits of the interpolation come from eight restoring division stages
// reset clears all stage valid bits; width returns to 1 and all tint bytes to 255
`timescale 1ns / 1ps
`include "horizontal_gradient_tint_macros.svh"

module horizontal_gradient_tint #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hgt_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [hgt_pkg::CFG_W-1:0]     cfg_data,
    hgt_stream_if.sink                    pix_in,
    hgt_stream_if.source                  pix_out
);

    localparam int N_STAGES  = 14;
    localparam int DIV_STEPS = hgt_pkg::QUO_W;
    localparam int ST_SCALE  = 12;
    localparam int WCAP_INT  = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
    localparam logic [hgt_pkg::WIDTH_W-1:0] WIDTH_CAP = hgt_pkg::WIDTH_W'(WCAP_INT);

    // configuration registers
    logic [hgt_pkg::WIDTH_W-1:0] width_reg;
    hgt_pkg::rgb_t               left_reg;
    hgt_pkg::rgb_t               right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= hgt_pkg::WIDTH_W'(1);
            for (int c = 0; c < hgt_pkg::NUM_CH; c++)
            begin
                left_reg[c]  <= hgt_pkg::CH_FULL;
                right_reg[c] <= hgt_pkg::CH_FULL;
            end
        end
        else if (cfg_we)
        begin
            case (hgt_pkg::reg_idx_t'(cfg_index))
                hgt_pkg::REG_IMAGE_WIDTH: width_reg    <= cfg_data[hgt_pkg::WIDTH_W-1:0];
                hgt_pkg::REG_LEFT_RED:    left_reg[0]  <= cfg_data[hgt_pkg::CH_W-1:0];
                hgt_pkg::REG_LEFT_GREEN:  left_reg[1]  <= cfg_data[hgt_pkg::CH_W-1:0];
                hgt_pkg::REG_LEFT_BLUE:   left_reg[2]  <= cfg_data[hgt_pkg::CH_W-1:0];
                hgt_pkg::REG_RIGHT_RED:   right_reg[0] <= cfg_data[hgt_pkg::CH_W-1:0];
                hgt_pkg::REG_RIGHT_GREEN: right_reg[1] <= cfg_data[hgt_pkg::CH_W-1:0];
                hgt_pkg::REG_RIGHT_BLUE:  right_reg[2] <= cfg_data[hgt_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    // effective width and last column
    logic [hgt_pkg::WIDTH_W-1:0] width_eff;
    logic [hgt_pkg::WIDTH_W-1:0] last_col;

    always_comb
    begin
        if (width_reg == '0)
            width_eff = hgt_pkg::WIDTH_W'(1);
        else if (width_reg > WIDTH_CAP)
            width_eff = WIDTH_CAP;
        else
            width_eff = width_reg;
        last_col = width_eff - hgt_pkg::WIDTH_W'(1);
    end

    // per-stage valid and ready chain
    logic [N_STAGES-1:0] vld_reg;
    logic [N_STAGES-1:0] vld_next;
    logic [N_STAGES-1:0] stage_load;
    logic                in_xfer;
    logic                out_xfer;

    always_comb
    begin
        stage_load[N_STAGES-1] = !vld_reg[N_STAGES-1] || pix_out.ready;
        for (int k = N_STAGES - 2; k >= 0; k--)
            stage_load[k] = !vld_reg[k] || stage_load[k+1];
    end

    assign pix_in.ready  = stage_load[0] && rst_n;
    assign in_xfer       = pix_in.valid && pix_in.ready;
    assign pix_out.valid = vld_reg[N_STAGES-1];
    assign out_xfer      = pix_out.valid && pix_out.ready;

    always_comb
    begin
        vld_next[0] = stage_load[0] ? in_xfer : vld_reg[0];
        for (int k = 1; k < N_STAGES; k++)
            vld_next[k] = stage_load[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // stage payloads
    hgt_pkg::in_item_t  s0_reg;
    hgt_pkg::lerp_t     s1_reg;
    hgt_pkg::lerp_t     s1_next;
    hgt_pkg::prod_t     s2_reg;
    hgt_pkg::prod_t     s2_next;
    hgt_pkg::div_t      dv_reg  [DIV_STEPS+1];
    hgt_pkg::div_t      dv_next [DIV_STEPS+1];
    hgt_pkg::scale_t    s12_reg;
    hgt_pkg::scale_t    s12_next;
    hgt_pkg::out_item_t s13_reg;
    hgt_pkg::out_item_t s13_next;

    // column clamp and denominator
    always_comb
    begin
        if ({1'b0, s0_reg.column} > last_col)
            s1_next.x = last_col[hgt_pkg::COL_W-1:0];
        else
            s1_next.x = s0_reg.column;
        s1_next.d     = (width_eff > hgt_pkg::WIDTH_W'(2)) ? last_col : hgt_pkg::WIDTH_W'(1);
        s1_next.rgb   = {s0_reg.in_blue, s0_reg.in_green, s0_reg.in_red};
        s1_next.alpha = s0_reg.in_alpha;
    end

    // left*(d-x) and right*x
    always_comb
    begin
        for (int c = 0; c < hgt_pkg::NUM_CH; c++)
        begin
            s2_next.lo[c] = hgt_pkg::NUM_W'(left_reg[c])
                          * hgt_pkg::NUM_W'(s1_reg.d - hgt_pkg::WIDTH_W'(s1_reg.x));
            s2_next.hi[c] = hgt_pkg::NUM_W'(right_reg[c]) * hgt_pkg::NUM_W'(s1_reg.x);
        end
        s2_next.d     = s1_reg.d;
        s2_next.rgb   = s1_reg.rgb;
        s2_next.alpha = s1_reg.alpha;
    end

    // numerator with half-denominator rounding, then one quotient bit per stage
    always_comb
    begin
        logic [hgt_pkg::NUM_W-1:0] dshift;
        logic                      ge;
        for (int c = 0; c < hgt_pkg::NUM_CH; c++)
        begin
            dv_next[0].rem[c] = s2_reg.lo[c] + s2_reg.hi[c]
                              + hgt_pkg::NUM_W'(s2_reg.d >> 1);
            dv_next[0].quo[c] = '0;
        end
        dv_next[0].d     = s2_reg.d;
        dv_next[0].rgb   = s2_reg.rgb;
        dv_next[0].alpha = s2_reg.alpha;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            dshift = hgt_pkg::NUM_W'(dv_reg[i].d) << (DIV_STEPS - 1 - i);
            for (int c = 0; c < hgt_pkg::NUM_CH; c++)
            begin
                ge = dv_reg[i].rem[c] >= dshift;
                dv_next[i+1].rem[c] = ge ? (dv_reg[i].rem[c] - dshift) : dv_reg[i].rem[c];
                dv_next[i+1].quo[c] = {dv_reg[i].quo[c][hgt_pkg::QUO_W-2:0], ge};
            end
            dv_next[i+1].d     = dv_reg[i].d;
            dv_next[i+1].rgb   = dv_reg[i].rgb;
            dv_next[i+1].alpha = dv_reg[i].alpha;
        end
    end

    // pixel times tint plus rounding bias
    always_comb
    begin
        for (int c = 0; c < hgt_pkg::NUM_CH; c++)
            s12_next.v[c] = hgt_pkg::PROD_W'(dv_reg[DIV_STEPS].rgb[c])
                          * hgt_pkg::PROD_W'(dv_reg[DIV_STEPS].quo[c])
                          + hgt_pkg::PROD_W'(hgt_pkg::ROUND_BIAS);
        s12_next.alpha = dv_reg[DIV_STEPS].alpha;
    end

    // divide by 255 as (v + (v >> 8) + 1) >> 8, exact for every v up to 255*255+127
    logic [hgt_pkg::NUM_CH-1:0][hgt_pkg::PROD_W:0] fold_sum;

    always_comb
    begin
        for (int c = 0; c < hgt_pkg::NUM_CH; c++)
            fold_sum[c] = {1'b0, s12_reg.v[c]}
                        + (hgt_pkg::PROD_W + 1)'(s12_reg.v[c] >> 8)
                        + (hgt_pkg::PROD_W + 1)'(1);
        s13_next.out_red   = fold_sum[0][hgt_pkg::PROD_W-1:8];
        s13_next.out_green = fold_sum[1][hgt_pkg::PROD_W-1:8];
        s13_next.out_blue  = fold_sum[2][hgt_pkg::PROD_W-1:8];
        s13_next.out_alpha = s12_reg.alpha;
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[0])
            s0_reg <= pix_in.data;
        if (stage_load[1])
            s1_reg <= s1_next;
        if (stage_load[2])
            s2_reg <= s2_next;
        for (int i = 0; i <= DIV_STEPS; i++)
        begin
            if (stage_load[3+i])
                dv_reg[i] <= dv_next[i];
        end
        if (stage_load[ST_SCALE])
            s12_reg <= s12_next;
        if (stage_load[N_STAGES-1])
            s13_reg <= s13_next;
    end

    assign pix_out.data = s13_reg;

    // checks
    `HGT_ASSERT_NEXT(a_occupancy, 1'b1,
        $countones(vld_reg) == $past($countones(vld_reg)) + int'($past(in_xfer))
            - int'($past(out_xfer)),
        "pipeline occupancy does not match transfers")
    `HGT_ASSERT_IMPLIES(a_full_stall, (&vld_reg) && !pix_out.ready, !pix_in.ready,
        "input taken while every stage is full and stalled")
    `HGT_ASSERT_IMPLIES(a_div_rem, vld_reg[ST_SCALE-1],
        (dv_reg[DIV_STEPS].rem[0] < hgt_pkg::NUM_W'(dv_reg[DIV_STEPS].d))
            && (dv_reg[DIV_STEPS].rem[1] < hgt_pkg::NUM_W'(dv_reg[DIV_STEPS].d))
            && (dv_reg[DIV_STEPS].rem[2] < hgt_pkg::NUM_W'(dv_reg[DIV_STEPS].d)),
        "division remainder not below denominator")

endmodule

/* verif/horizontal_gradient_tint_test.sv */
// self-checking testbench for the horizontal gradient tint pipeline
`timescale 1ns / 1ps

module horizontal_gradient_tint_test;

    localparam int MAX_WIDTH = 4096;
    localparam int PIPE_LATENCY = 13;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 50;
    localparam logic [hgt_pkg::REG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef enum bit {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct {
        row_kind_t                     kind;
        logic [hgt_pkg::REG_IDX_W-1:0] idx;
        logic [hgt_pkg::CFG_W-1:0]     value;
        hgt_pkg::in_item_t             px;
        bit                            typed;
        hgt_pkg::out_item_t            want;
    } dir_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [hgt_pkg::REG_IDX_W-1:0] cfg_index;
    logic [hgt_pkg::CFG_W-1:0]     cfg_data;

    hgt_stream_if #(.T(hgt_pkg::in_item_t))  pix_in_if ();
    hgt_stream_if #(.T(hgt_pkg::out_item_t)) pix_out_if ();

    horizontal_gradient_tint #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pix_in(pix_in_if),
        .pix_out(pix_out_if)
    );

    logic [hgt_pkg::WIDTH_W-1:0] width_reg;
    hgt_pkg::chan_t              left_tint [3];
    hgt_pkg::chan_t              right_tint [3];

    hgt_pkg::out_item_t pending_pixels[$];
    dir_row_t           directed_rows[$];
    int                 mismatch_count = 0;
    int                 pixels_sent = 0;
    int                 pixels_checked = 0;
    int                 settings_used = 1;
    bit                 idle_on = 1'b1;
    bit                 stall_on = 1'b1;
    bit                 quiet_tail = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic hgt_pkg::out_item_t tint_pixel(hgt_pkg::in_item_t px);
        int unsigned        w;
        int unsigned        x;
        int unsigned        d;
        int unsigned        num;
        int unsigned        tint [3];
        int unsigned        src [3];
        hgt_pkg::out_item_t res;
        w = width_reg;
        if (w == 0)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        x = px.column;
        if (x > w - 1)
            x = w - 1;
        d = (w > 2) ? w - 1 : 1;
        src[0] = px.in_red;
        src[1] = px.in_green;
        src[2] = px.in_blue;
        for (int c = 0; c < 3; c++)
        begin
            num = left_tint[c] * (d - x) + right_tint[c] * x + d / 2;
            tint[c] = (num / d) & 8'hFF;
            src[c] = (src[c] * tint[c] + 127) / 255;
        end
        res.out_red = src[0][7:0];
        res.out_green = src[1][7:0];
        res.out_blue = src[2][7:0];
        res.out_alpha = px.in_alpha;
        return res;
    endfunction

    function automatic hgt_pkg::chan_t rand_byte();
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return hgt_pkg::chan_t'($urandom_range(0, 255));
    endfunction

    function automatic hgt_pkg::in_item_t make_pixel(int col, hgt_pkg::chan_t r,
                                                     hgt_pkg::chan_t g, hgt_pkg::chan_t b,
                                                     hgt_pkg::chan_t a);
        hgt_pkg::in_item_t px;
        px.column = col[hgt_pkg::COL_W-1:0];
        px.in_red = r;
        px.in_green = g;
        px.in_blue = b;
        px.in_alpha = a;
        return px;
    endfunction

    function automatic void add_cfg(logic [hgt_pkg::REG_IDX_W-1:0] idx,
                                    logic [hgt_pkg::CFG_W-1:0] value);
        dir_row_t row;
        row.kind = ROW_CFG;
        row.idx = idx;
        row.value = value;
        row.px = '0;
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pix(int col, hgt_pkg::chan_t r, hgt_pkg::chan_t g,
                                    hgt_pkg::chan_t b, hgt_pkg::chan_t a);
        dir_row_t row;
        row.kind = ROW_PIX;
        row.idx = '0;
        row.value = '0;
        row.px = make_pixel(col, r, g, b, a);
        row.typed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_typed(int col, hgt_pkg::chan_t r, hgt_pkg::chan_t g,
                                      hgt_pkg::chan_t b, hgt_pkg::chan_t a,
                                      hgt_pkg::chan_t er, hgt_pkg::chan_t eg,
                                      hgt_pkg::chan_t eb);
        dir_row_t row;
        row.kind = ROW_PIX;
        row.idx = '0;
        row.value = '0;
        row.px = make_pixel(col, r, g, b, a);
        row.typed = 1'b1;
        row.want = '{out_red: er, out_green: eg, out_blue: eb, out_alpha: a};
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at result %0d: %s", pixels_checked, msg);
        mismatch_count++;
    endtask

    task automatic write_reg(logic [hgt_pkg::REG_IDX_W-1:0] idx,
                             logic [hgt_pkg::CFG_W-1:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            hgt_pkg::REG_IMAGE_WIDTH: width_reg = value[hgt_pkg::WIDTH_W-1:0];
            hgt_pkg::REG_LEFT_RED:    left_tint[0] = value[hgt_pkg::CH_W-1:0];
            hgt_pkg::REG_LEFT_GREEN:  left_tint[1] = value[hgt_pkg::CH_W-1:0];
            hgt_pkg::REG_LEFT_BLUE:   left_tint[2] = value[hgt_pkg::CH_W-1:0];
            hgt_pkg::REG_RIGHT_RED:   right_tint[0] = value[hgt_pkg::CH_W-1:0];
            hgt_pkg::REG_RIGHT_GREEN: right_tint[1] = value[hgt_pkg::CH_W-1:0];
            hgt_pkg::REG_RIGHT_BLUE:  right_tint[2] = value[hgt_pkg::CH_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_drain();
        pix_in_if.valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 3) @(negedge clk);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_pixel(hgt_pkg::in_item_t px, bit typed, hgt_pkg::out_item_t want);
        pix_in_if.data = px;
        pix_in_if.valid = 1'b1;
        @(posedge clk);
        while (!pix_in_if.ready)
            @(posedge clk);
        pending_pixels.push_back(typed ? want : tint_pixel(px));
        pixels_sent++;
        @(negedge clk);
        if (idle_on && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            pix_in_if.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
    endtask

    initial
    begin
        pix_out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_on && !quiet_tail && $urandom_range(0, 5) == 0)
            begin
                pix_out_if.ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            pix_out_if.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        hgt_pkg::out_item_t got;
        hgt_pkg::out_item_t want;
        if (rst_n && pix_out_if.valid && pix_out_if.ready)
        begin
            got = pix_out_if.data;
            if (pending_pixels.size() == 0)
                report_mismatch($sformatf("result with nothing pending (%h)", got));
            else
            begin
                want = pending_pixels.pop_front();
                if (got.out_red !== want.out_red)
                    report_mismatch($sformatf("out_red got %0d want %0d",
                                              got.out_red, want.out_red));
                if (got.out_green !== want.out_green)
                    report_mismatch($sformatf("out_green got %0d want %0d",
                                              got.out_green, want.out_green));
                if (got.out_blue !== want.out_blue)
                    report_mismatch($sformatf("out_blue got %0d want %0d",
                                              got.out_blue, want.out_blue));
                if (got.out_alpha !== want.out_alpha)
                    report_mismatch($sformatf("out_alpha got %0d want %0d",
                                              got.out_alpha, want.out_alpha));
            end
            pixels_checked++;
        end
    end

    initial
    begin
        int unsigned w_eff;
        int          col;
        bit          prev_pix;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix_in_if.valid = 1'b0;
        pix_in_if.data = '0;
        width_reg = 13'd1;
        for (int c = 0; c < 3; c++)
        begin
            left_tint[c] = hgt_pkg::CH_FULL;
            right_tint[c] = hgt_pkg::CH_FULL;
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset tint is full white, so pixels pass unchanged
        add_typed(0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        add_typed(4095, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        add_typed(2048, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h55, 8'hAA, 8'h0F);
        add_typed(1, 8'd1, 8'd128, 8'd254, 8'h80, 8'd1, 8'd128, 8'd254);
        // zero width, black left edge, upper data bits ignored on bytes
        add_cfg(hgt_pkg::REG_IMAGE_WIDTH, 13'd0);
        add_cfg(hgt_pkg::REG_LEFT_RED, 13'h1F00);
        add_cfg(hgt_pkg::REG_LEFT_GREEN, 13'h1F00);
        add_cfg(hgt_pkg::REG_LEFT_BLUE, 13'h1F00);
        add_cfg(hgt_pkg::REG_RIGHT_RED, 13'h00FF);
        add_cfg(hgt_pkg::REG_RIGHT_GREEN, 13'h00FF);
        add_cfg(hgt_pkg::REG_RIGHT_BLUE, 13'h00FF);
        add_typed(4095, 8'd200, 8'd100, 8'd50, 8'd9, 8'd0, 8'd0, 8'd0);
        add_typed(0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
        // width saturates to the maximum
        add_cfg(hgt_pkg::REG_IMAGE_WIDTH, 13'd8191);
        add_typed(4095, 8'd17, 8'd34, 8'd51, 8'd68, 8'd17, 8'd34, 8'd51);
        add_typed(0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
        add_pix(2047, 8'd255, 8'd255, 8'd255, 8'd1);
        add_pix(2048, 8'd200, 8'd127, 8'd3, 8'd2);
        add_cfg(hgt_pkg::REG_IMAGE_WIDTH, 13'd4096);
        add_pix(4095, 8'd99, 8'd255, 8'd128, 8'd3);
        add_pix(1000, 8'd255, 8'd77, 8'd0, 8'd4);
        add_cfg(hgt_pkg::REG_IMAGE_WIDTH, 13'd2);
        add_pix(0, 8'd255, 8'd128, 8'd1, 8'd5);
        add_pix(1, 8'd255, 8'd128, 8'd1, 8'd6);
        add_pix(3000, 8'd10, 8'd20, 8'd30, 8'd7);
        add_cfg(hgt_pkg::REG_IMAGE_WIDTH, 13'd3);
        add_pix(1, 8'd255, 8'd255, 8'd255, 8'd8);
        add_pix(2, 8'd128, 8'd64, 8'd32, 8'd9);
        // write to an unused index must change nothing
        add_cfg(REG_NONE, 13'h1FFF);
        add_pix(1, 8'd255, 8'd129, 8'd2, 8'd10);
        add_cfg(hgt_pkg::REG_IMAGE_WIDTH, 13'd4097);
        add_cfg(hgt_pkg::REG_LEFT_RED, 13'hFF);
        add_cfg(hgt_pkg::REG_LEFT_GREEN, 13'hFF);
        add_cfg(hgt_pkg::REG_LEFT_BLUE, 13'hFF);
        add_cfg(hgt_pkg::REG_RIGHT_RED, 13'h1E00);
        add_cfg(hgt_pkg::REG_RIGHT_GREEN, 13'h1E00);
        add_cfg(hgt_pkg::REG_RIGHT_BLUE, 13'h1E00);
        add_typed(4095, 8'd90, 8'd180, 8'd255, 8'd11, 8'd0, 8'd0, 8'd0);
        add_typed(0, 8'd90, 8'd180, 8'd255, 8'd12, 8'd90, 8'd180, 8'd255);

        prev_pix = 1'b0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                if (prev_pix)
                begin
                    wait_drain();
                    settings_used++;
                end
                write_reg(directed_rows[i].idx, directed_rows[i].value);
                prev_pix = 1'b0;
            end
            else
            begin
                send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
                prev_pix = 1'b1;
            end
        end

        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            wait_drain();
            settings_used++;
            quiet_tail = (phase >= RAND_PHASES - 2);
            idle_on = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
                0: w_eff = 0;
                1: w_eff = 1;
                2: w_eff = 2;
                3: w_eff = $urandom_range(3, 16);
                4: w_eff = $urandom_range(17, 4096);
                5: w_eff = 4096;
                6: w_eff = $urandom_range(4097, 8191);
                default: w_eff = $urandom_range(0, 8191);
            endcase
            write_reg(hgt_pkg::REG_IMAGE_WIDTH, w_eff[hgt_pkg::CFG_W-1:0]);
            write_reg(hgt_pkg::REG_LEFT_RED, {5'($urandom_range(0, 31)), rand_byte()});
            write_reg(hgt_pkg::REG_LEFT_GREEN, {5'($urandom_range(0, 31)), rand_byte()});
            write_reg(hgt_pkg::REG_LEFT_BLUE, {5'($urandom_range(0, 31)), rand_byte()});
            write_reg(hgt_pkg::REG_RIGHT_RED, {5'($urandom_range(0, 31)), rand_byte()});
            write_reg(hgt_pkg::REG_RIGHT_GREEN, {5'($urandom_range(0, 31)), rand_byte()});
            write_reg(hgt_pkg::REG_RIGHT_BLUE, {5'($urandom_range(0, 31)), rand_byte()});
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_NONE, 13'($urandom_range(0, 8191)));
            w_eff = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2 && phase % 4 == 1)
                    wait_drain();
                case ($urandom_range(0, 5))
                    0: col = 0;
                    1: col = w_eff - 1;
                    2, 3: col = $urandom_range(0, w_eff - 1);
                    4: col = $urandom_range(0, 4095);
                    default: col = $urandom_range(w_eff - 1, 4095);
                endcase
                send_pixel(make_pixel(col, rand_byte(), rand_byte(), rand_byte(),
                                      hgt_pkg::chan_t'($urandom_range(0, 255))), 1'b0, '0);
            end
        end

        wait_drain();
        $display("%0d pixels sent and %0d results checked under %0d register settings,",
                 pixels_sent, pixels_checked, settings_used);
        $display("covering zero, saturated and clamped widths and out-of-range columns");
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
